// ----- rtl/lhs_pkg.sv -----
// shared types, constants and rounding helper for the lambertian hemisphere sample unit
package lhs_pkg;

   localparam int CMP_W    = 16;            // q2.14 component width
   localparam int FRAC_W   = 14;            // fraction bits of q2.14
   localparam int WIDE_W   = 34;            // exact vector component before normalize
   localparam int MAG_W    = 31;            // magnitude after range shift
   localparam int SUM_W    = 64;            // sum of squares
   localparam int ROOT_W   = 32;            // integer square root
   localparam int QUO_W    = 15;            // normalized magnitude, at most 2^14
   localparam int REM_W    = 46;            // dividend of the normalize divide
   localparam int PROD_W   = 32;            // q2.14 times q2.14
   localparam int DEN_W    = 50;            // dot product times 1/pi
   localparam int CSR_IDX_W = 8;
   localparam int ONE_Q14  = 1 << FRAC_W;

   // jittered up vector in q2.14, 1/pi in unsigned q0.16
   localparam int UP_X   = 56;
   localparam int UP_Y   = 16384;
   localparam int UP_Z   = 116;
   localparam int INV_PI = 20861;

   typedef logic signed [CMP_W-1:0]  q14_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef q14_type [2:0]            vec_type;

   typedef enum logic [1:0] {
      CSR_DIFFUSE_GAIN,
      CSR_COLOR_RED,
      CSR_COLOR_GREEN,
      CSR_COLOR_BLUE
   } csr_idx_type;

   typedef struct packed {
      logic signed [CMP_W-1:0] normal_x;
      logic signed [CMP_W-1:0] normal_y;
      logic signed [CMP_W-1:0] normal_z;
      logic signed [CMP_W-1:0] sample_x;
      logic signed [CMP_W-1:0] sample_y;
      logic signed [CMP_W-1:0] sample_z;
   } req_type;

   typedef struct packed {
      logic signed [CMP_W-1:0] dir_x;
      logic signed [CMP_W-1:0] dir_y;
      logic signed [CMP_W-1:0] dir_z;
      logic signed [CMP_W-1:0] density;
      logic [CMP_W-1:0]        refl_red;
      logic [CMP_W-1:0]        refl_green;
      logic [CMP_W-1:0]        refl_blue;
   } rsp_type;

   // shift right rounding half away from zero, saturate to q2.14
   function automatic q14_type round_sat(input logic signed [63:0] val, input logic [5:0] sh);
      logic [63:0] mag;
      logic [63:0] half;
      logic [63:0] rnd;
      mag  = val[63] ? 64'(-val) : 64'(val);
      half = 64'd1 << (sh - 6'd1);
      rnd  = (mag + half) >> sh;
      if (!val[63]) begin
         if (rnd > 64'd32767) return 16'sh7fff;
         return q14_type'(rnd[CMP_W-1:0]);
      end
      if (rnd > 64'd32768) return 16'sh8000;
      return q14_type'(-rnd[CMP_W-1:0]);
   endfunction

endpackage

// ----- rtl/lhs_norm.sv -----
// pipelined vector normalize: range shift, sum of squares, square root, divide
module lhs_norm #(
   parameter int PW = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  lhs_pkg::wide_type [2:0] in_comp,
   input  logic [PW-1:0]           in_side,
   output logic                    out_valid,
   input  logic                    out_ready,
   output lhs_pkg::vec_type        out_vec,
   output logic [PW-1:0]           out_side
);
   import lhs_pkg::*;

   localparam int NROOT  = ROOT_W;
   localparam int NQUO   = QUO_W;
   localparam int K_ROOT = 3;
   localparam int K_PREP = K_ROOT + NROOT;
   localparam int K_DIV  = K_PREP + 1;
   localparam int K_OUT  = K_DIV + NQUO;
   localparam int NST    = K_OUT + 1;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] m;
      logic [2:0]            neg;
      logic [PW-1:0]         side;
   } carry_type;

   typedef struct packed {
      logic [SUM_W-1:0] x;
      logic [SUM_W-1:0] r;
      carry_type        c;
   } root_type;

   typedef struct packed {
      logic [2:0][REM_W-1:0] rem;
      logic [2:0][QUO_W-1:0] q;
      logic [ROOT_W-1:0]     len;
      logic [2:0]            neg;
      logic [PW-1:0]         side;
   } div_type;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_src;
   logic [NST:0]   en;

   // stage k may load when it is empty or its content moves on
   assign en[NST] = out_ready;
   for (genvar k = 0; k < NST; k++) begin : g_en
      assign en[k] = ~vld_ff[k] | en[k+1];
   end
   assign vld_src  = {vld_ff[NST-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) vld_ff[k] <= vld_src[k];
         end
      end
   end

   // range shift
   logic [2:0][WIDE_W-1:0] mag;
   logic [WIDE_W-1:0]      mag_or;
   logic [1:0]             sh;
   carry_type              p0_in;
   carry_type              p0_ff;
   carry_type              p1_c_ff;
   carry_type              p2_c_ff;
   logic [2:0][2*MAG_W-1:0] p1_sq_ff;
   logic [SUM_W-1:0]       p2_sum_ff;

   always_comb begin
      mag_or = '0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = in_comp[i][WIDE_W-1] ? WIDE_W'(-$signed(in_comp[i])) : WIDE_W'(in_comp[i]);
         mag_or = mag_or | mag[i];
      end
      if (mag_or[WIDE_W-1])      sh = 2'd3;
      else if (mag_or[WIDE_W-2]) sh = 2'd2;
      else if (mag_or[MAG_W])    sh = 2'd1;
      else                       sh = 2'd0;
      for (int i = 0; i < 3; i++) begin
         p0_in.m[i]   = MAG_W'(mag[i] >> sh);
         p0_in.neg[i] = in_comp[i][WIDE_W-1];
      end
      p0_in.side = in_side;
   end

   always_ff @(posedge clock) begin
      if (en[0]) p0_ff <= p0_in;
      if (en[1]) begin
         p1_c_ff <= p0_ff;
         for (int i = 0; i < 3; i++) begin
            p1_sq_ff[i] <= (2*MAG_W)'(p0_ff.m[i]) * (2*MAG_W)'(p0_ff.m[i]);
         end
      end
      if (en[2]) begin
         p2_c_ff   <= p1_c_ff;
         p2_sum_ff <= SUM_W'(p1_sq_ff[0]) + SUM_W'(p1_sq_ff[1]) + SUM_W'(p1_sq_ff[2]);
      end
   end

   // square root, one result bit per stage
   root_type root_ff [NROOT];

   for (genvar j = 0; j < NROOT; j++) begin : g_root
      localparam logic [SUM_W-1:0] STEP_BIT = SUM_W'(1) << (SUM_W - 2 - 2*j);
      root_type         src_w;
      root_type         root_in;
      logic [SUM_W-1:0] trial_w;

      if (j == 0) begin : g_head
         always_comb begin
            src_w.x = p2_sum_ff;
            src_w.r = '0;
            src_w.c = p2_c_ff;
         end
      end else begin : g_body
         assign src_w = root_ff[j-1];
      end

      always_comb begin
         trial_w = src_w.r + STEP_BIT;
         root_in = src_w;
         if (src_w.x >= trial_w) begin
            root_in.x = src_w.x - trial_w;
            root_in.r = (src_w.r >> 1) + STEP_BIT;
         end else begin
            root_in.r = src_w.r >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en[K_ROOT+j]) root_ff[j] <= root_in;
      end
   end

   // dividend with half the length added for rounding
   logic [ROOT_W-1:0] len_w;
   div_type           prep_in;
   div_type           prep_ff;

   always_comb begin
      len_w = root_ff[NROOT-1].r[ROOT_W-1:0];
      for (int i = 0; i < 3; i++) begin
         prep_in.rem[i] = (REM_W'(root_ff[NROOT-1].c.m[i]) << FRAC_W) + REM_W'(len_w >> 1);
      end
      prep_in.q    = '0;
      prep_in.len  = len_w;
      prep_in.neg  = root_ff[NROOT-1].c.neg;
      prep_in.side = root_ff[NROOT-1].c.side;
   end

   always_ff @(posedge clock) begin
      if (en[K_PREP]) prep_ff <= prep_in;
   end

   // restoring divide, one quotient bit per stage, three lanes
   div_type div_ff [NQUO];

   for (genvar j = 0; j < NQUO; j++) begin : g_div
      localparam int QB = NQUO - 1 - j;
      div_type          src_w;
      div_type          div_in;
      logic [REM_W:0]   dv_w;

      if (j == 0) begin : g_head
         assign src_w = prep_ff;
      end else begin : g_body
         assign src_w = div_ff[j-1];
      end

      always_comb begin
         dv_w   = (REM_W+1)'(src_w.len) << QB;
         div_in = src_w;
         for (int i = 0; i < 3; i++) begin
            if ({1'b0, src_w.rem[i]} >= dv_w) begin
               div_in.rem[i]    = src_w.rem[i] - dv_w[REM_W-1:0];
               div_in.q[i][QB]  = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[K_DIV+j]) div_ff[j] <= div_in;
      end
   end

   // sign and zero-length
   vec_type       out_in;
   vec_type       out_ff;
   logic [PW-1:0] side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (div_ff[NQUO-1].len == '0) begin
            out_in[i] = '0;
         end else if (div_ff[NQUO-1].neg[i]) begin
            out_in[i] = q14_type'(-{1'b0, div_ff[NQUO-1].q[i]});
         end else begin
            out_in[i] = q14_type'({1'b0, div_ff[NQUO-1].q[i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[K_OUT]) begin
         out_ff  <= out_in;
         side_ff <= div_ff[NQUO-1].side;
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_vec   = out_ff;
   assign out_side  = side_ff;

   // a normalized component never exceeds one
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ($signed(out_vec[0]) <= ONE_Q14 && $signed(out_vec[0]) >= -ONE_Q14 &&
                     $signed(out_vec[1]) <= ONE_Q14 && $signed(out_vec[1]) >= -ONE_Q14 &&
                     $signed(out_vec[2]) <= ONE_Q14 && $signed(out_vec[2]) >= -ONE_Q14))
      else $error("normalized component out of range");

endmodule

// ----- rtl/lhs_basis.sv -----
// basis pipeline: u = v x w, then wi = s.x*u + s.y*v + s.z*w
module lhs_basis (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  lhs_pkg::vec_type        in_v,
   input  lhs_pkg::req_type        in_req,
   output logic                    out_valid,
   input  logic                    out_ready,
   output lhs_pkg::wide_type [2:0] out_wi,
   output lhs_pkg::vec_type        out_nrm
);
   import lhs_pkg::*;

   localparam int NST = 5;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_src;
   logic [NST:0]   en;

   assign en[NST] = out_ready;
   for (genvar k = 0; k < NST; k++) begin : g_en
      assign en[k] = ~vld_ff[k] | en[k+1];
   end
   assign vld_src  = {vld_ff[NST-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) vld_ff[k] <= vld_src[k];
         end
      end
   end

   vec_type w_in;
   assign w_in[0] = in_req.normal_x;
   assign w_in[1] = in_req.normal_y;
   assign w_in[2] = in_req.normal_z;

   logic [5:0][PROD_W-1:0] b0_prod_ff;
   vec_type                b0_v_ff;
   req_type                b0_req_ff;
   logic [2:0][PROD_W:0]   b1_diff_ff;
   vec_type                b1_v_ff;
   req_type                b1_req_ff;
   vec_type                b2_u_ff;
   vec_type                b2_v_ff;
   req_type                b2_req_ff;
   logic [8:0][PROD_W-1:0] b3_prod_ff;
   vec_type                b3_w_ff;
   logic [2:0][WIDE_W-1:0] b4_wi_ff;
   vec_type                b4_w_ff;
   vec_type                b2_w_w;

   assign b2_w_w[0] = b2_req_ff.normal_x;
   assign b2_w_w[1] = b2_req_ff.normal_y;
   assign b2_w_w[2] = b2_req_ff.normal_z;

   always_ff @(posedge clock) begin
      // cross product terms of v x w
      if (en[0]) begin
         b0_prod_ff[0] <= PROD_W'($signed(in_v[1]) * $signed(w_in[2]));
         b0_prod_ff[1] <= PROD_W'($signed(in_v[2]) * $signed(w_in[1]));
         b0_prod_ff[2] <= PROD_W'($signed(in_v[2]) * $signed(w_in[0]));
         b0_prod_ff[3] <= PROD_W'($signed(in_v[0]) * $signed(w_in[2]));
         b0_prod_ff[4] <= PROD_W'($signed(in_v[0]) * $signed(w_in[1]));
         b0_prod_ff[5] <= PROD_W'($signed(in_v[1]) * $signed(w_in[0]));
         b0_v_ff       <= in_v;
         b0_req_ff     <= in_req;
      end
      if (en[1]) begin
         for (int i = 0; i < 3; i++) begin
            b1_diff_ff[i] <= (PROD_W+1)'($signed(b0_prod_ff[2*i])) -
                             (PROD_W+1)'($signed(b0_prod_ff[2*i+1]));
         end
         b1_v_ff   <= b0_v_ff;
         b1_req_ff <= b0_req_ff;
      end
      if (en[2]) begin
         for (int i = 0; i < 3; i++) begin
            b2_u_ff[i] <= round_sat(64'($signed(b1_diff_ff[i])), 6'(FRAC_W));
         end
         b2_v_ff   <= b1_v_ff;
         b2_req_ff <= b1_req_ff;
      end
      // sample mapped into the basis
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            b3_prod_ff[3*i]   <= PROD_W'(b2_req_ff.sample_x * $signed(b2_u_ff[i]));
            b3_prod_ff[3*i+1] <= PROD_W'(b2_req_ff.sample_y * $signed(b2_v_ff[i]));
            b3_prod_ff[3*i+2] <= PROD_W'(b2_req_ff.sample_z * $signed(b2_w_w[i]));
         end
         b3_w_ff <= b2_w_w;
      end
      if (en[4]) begin
         for (int i = 0; i < 3; i++) begin
            b4_wi_ff[i] <= WIDE_W'($signed(b3_prod_ff[3*i])) +
                           WIDE_W'($signed(b3_prod_ff[3*i+1])) +
                           WIDE_W'($signed(b3_prod_ff[3*i+2]));
         end
         b4_w_ff <= b3_w_ff;
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_nrm   = b4_w_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) out_wi[i] = wide_type'(b4_wi_ff[i]);
   end

endmodule

// ----- rtl/lhs_finish.sv -----
// density pipeline: dot(w, wi) scaled by 1/pi, output register
module lhs_finish (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  lhs_pkg::vec_type in_dir,
   input  lhs_pkg::vec_type in_nrm,
   output logic             out_valid,
   input  logic             out_ready,
   output lhs_pkg::vec_type out_dir,
   output lhs_pkg::q14_type out_density
);
   import lhs_pkg::*;

   localparam int NST = 4;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_src;
   logic [NST:0]   en;

   assign en[NST] = out_ready;
   for (genvar k = 0; k < NST; k++) begin : g_en
      assign en[k] = ~vld_ff[k] | en[k+1];
   end
   assign vld_src  = {vld_ff[NST-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) vld_ff[k] <= vld_src[k];
         end
      end
   end

   logic [2:0][PROD_W-1:0] f0_prod_ff;
   vec_type                f0_dir_ff;
   logic [WIDE_W-1:0]      f1_dot_ff;
   vec_type                f1_dir_ff;
   logic [DEN_W-1:0]       f2_scaled_ff;
   vec_type                f2_dir_ff;
   vec_type                f3_dir_ff;
   q14_type                f3_density_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            f0_prod_ff[i] <= PROD_W'($signed(in_nrm[i]) * $signed(in_dir[i]));
         end
         f0_dir_ff <= in_dir;
      end
      if (en[1]) begin
         f1_dot_ff <= WIDE_W'($signed(f0_prod_ff[0])) + WIDE_W'($signed(f0_prod_ff[1])) +
                      WIDE_W'($signed(f0_prod_ff[2]));
         f1_dir_ff <= f0_dir_ff;
      end
      if (en[2]) begin
         f2_scaled_ff <= DEN_W'($signed(f1_dot_ff)) * DEN_W'(INV_PI);
         f2_dir_ff    <= f1_dir_ff;
      end
      if (en[3]) begin
         f3_density_ff <= round_sat(64'($signed(f2_scaled_ff)), 6'd30);
         f3_dir_ff     <= f2_dir_ff;
      end
   end

   assign out_valid   = vld_ff[NST-1];
   assign out_dir     = f3_dir_ff;
   assign out_density = f3_density_ff;

   // a zero direction has zero density
   a_zero_dir: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_dir[0] == '0 && out_dir[1] == '0 && out_dir[2] == '0)
      |-> out_density == '0)
      else $error("nonzero density for zero direction");

endmodule

// ----- rtl/lambertian_hemisphere_sample_unit.sv -----
// top level of the lambertian hemisphere sample unit
// pipeline: cross stage, normalize, basis, normalize, density; the square root
//   (32 stages) and the divide (15 stages) make up most of each normalize
// throughput: one request per cycle; a stalled result only holds the stages behind it
// reset: synchronous, clears every valid bit and the four configuration registers
module lambertian_hemisphere_sample_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  lhs_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output lhs_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lhs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lhs_pkg::CMP_W-1:0]       csr_data
);
   import lhs_pkg::*;

   // ---------------------------------------------------------------
   // configuration registers, always writable
   // ---------------------------------------------------------------
   logic [CMP_W-1:0]      kd_ff;
   logic [2:0][CMP_W-1:0] col_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kd_ff  <= '0;
         col_ff <= '0;
      end else if (csr_valid && csr_ready && csr_index[CSR_IDX_W-1:2] == '0) begin
         // indexes past the last register fall through untouched
         unique case (csr_idx_type'(csr_index[1:0]))
            CSR_DIFFUSE_GAIN: kd_ff     <= csr_data;
            CSR_COLOR_RED:    col_ff[0] <= csr_data;
            CSR_COLOR_GREEN:  col_ff[1] <= csr_data;
            CSR_COLOR_BLUE:   col_ff[2] <= csr_data;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // reflectance kd*color/pi; depends on registers only, so it runs
   // free and settles through its product, scale and round registers
   // after a write, long before any request gets through the pipeline
   // ---------------------------------------------------------------
   logic [2:0][2*CMP_W-1:0]      kc_ff;
   logic [2:0][2*CMP_W+15-1:0]   kp_ff;
   logic [2:0][CMP_W-1:0]        refl_ff;
   logic [2:0][2*CMP_W+15-30:0]  refl_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // round half up after the 1/pi scale
         refl_in[i] = (2*CMP_W+15-29)'((kp_ff[i] + (2*CMP_W+15)'(1 << 29)) >> 30);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         kc_ff[i]   <= (2*CMP_W)'(kd_ff) * (2*CMP_W)'(col_ff[i]);
         kp_ff[i]   <= (2*CMP_W+15)'(kc_ff[i]) * (2*CMP_W+15)'(INV_PI);
         refl_ff[i] <= (refl_in[i] > (2*CMP_W+15-29)'(16'hffff)) ? 16'hffff
                                                                 : refl_in[i][CMP_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // front stage: t = up x w, constant multipliers only
   // ---------------------------------------------------------------
   logic                   fr_vld_ff;
   logic                   fr_en;
   logic [2:0][WIDE_W-1:0] fr_t_ff;
   req_type                fr_req_ff;
   logic                   n1_in_ready;

   assign fr_en     = ~fr_vld_ff | n1_in_ready;
   assign req_ready = fr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_vld_ff <= 1'b0;
      end else if (fr_en) begin
         fr_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fr_en) begin
         fr_t_ff[0] <= WIDE_W'(UP_Y) * WIDE_W'(req_data.normal_z) -
                       WIDE_W'(UP_Z) * WIDE_W'(req_data.normal_y);
         fr_t_ff[1] <= WIDE_W'(UP_Z) * WIDE_W'(req_data.normal_x) -
                       WIDE_W'(UP_X) * WIDE_W'(req_data.normal_z);
         fr_t_ff[2] <= WIDE_W'(UP_X) * WIDE_W'(req_data.normal_y) -
                       WIDE_W'(UP_Y) * WIDE_W'(req_data.normal_x);
         fr_req_ff  <= req_data;
      end
   end

   wide_type [2:0] fr_t_w;
   always_comb begin
      for (int i = 0; i < 3; i++) fr_t_w[i] = wide_type'(fr_t_ff[i]);
   end

   // ---------------------------------------------------------------
   // v = normalize(up x w), request rides along as side data
   // ---------------------------------------------------------------
   logic    n1_out_valid;
   logic    bs_in_ready;
   vec_type n1_v;
   req_type n1_req;

   lhs_norm #(
      .PW ($bits(req_type))
   ) u_norm_v (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_vld_ff),
      .in_ready  (n1_in_ready),
      .in_comp   (fr_t_w),
      .in_side   (fr_req_ff),
      .out_valid (n1_out_valid),
      .out_ready (bs_in_ready),
      .out_vec   (n1_v),
      .out_side  (n1_req)
   );

   // ---------------------------------------------------------------
   // u = v x w rounded, then the sample in that basis
   // ---------------------------------------------------------------
   logic           bs_out_valid;
   logic           n2_in_ready;
   wide_type [2:0] bs_wi;
   vec_type        bs_nrm;

   lhs_basis u_basis (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n1_out_valid),
      .in_ready  (bs_in_ready),
      .in_v      (n1_v),
      .in_req    (n1_req),
      .out_valid (bs_out_valid),
      .out_ready (n2_in_ready),
      .out_wi    (bs_wi),
      .out_nrm   (bs_nrm)
   );

   // ---------------------------------------------------------------
   // direction = normalize(wi), normal rides along for the density
   // ---------------------------------------------------------------
   logic    n2_out_valid;
   logic    fn_in_ready;
   vec_type n2_dir;
   vec_type n2_nrm;

   lhs_norm #(
      .PW ($bits(vec_type))
   ) u_norm_dir (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (bs_out_valid),
      .in_ready  (n2_in_ready),
      .in_comp   (bs_wi),
      .in_side   (bs_nrm),
      .out_valid (n2_out_valid),
      .out_ready (fn_in_ready),
      .out_vec   (n2_dir),
      .out_side  (n2_nrm)
   );

   // ---------------------------------------------------------------
   // density and output register
   // ---------------------------------------------------------------
   vec_type fn_dir;
   q14_type fn_density;

   lhs_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (n2_out_valid),
      .in_ready    (fn_in_ready),
      .in_dir      (n2_dir),
      .in_nrm      (n2_nrm),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_dir     (fn_dir),
      .out_density (fn_density)
   );

   always_comb begin
      rsp_data.dir_x      = fn_dir[0];
      rsp_data.dir_y      = fn_dir[1];
      rsp_data.dir_z      = fn_dir[2];
      rsp_data.density    = fn_density;
      rsp_data.refl_red   = refl_ff[0];
      rsp_data.refl_green = refl_ff[1];
      rsp_data.refl_blue  = refl_ff[2];
   end

   // clearing the gain zeroes every reflectance channel once it has passed the gain, product, scale and round registers
   a_gain_zero: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index == CSR_IDX_W'(CSR_DIFFUSE_GAIN) && csr_data == '0)
      |-> ##4 (refl_ff[0] == '0 && refl_ff[1] == '0 && refl_ff[2] == '0))
      else $error("reflectance not cleared after zero gain");

endmodule
